FILE: hdl/mpe_pkg.sv
// ============================================================================
// mpe_pkg - shared types and constants
// Item structs, command codes and the controller-to-datapath command bundle.
// ============================================================================
package mpe_pkg;

    // Input item carries four variable fields whatever NUM_VARS is
    localparam int NUM_VAR_FIELDS = 4;
    localparam int VAR_IDX_W      = 2;

    // Coefficient store, addressed by the 4-bit load index
    localparam int COEF_IDX_W = 4;
    localparam int TAB_N      = 16;

    // Exponents and degrees (DEGREE up to 4)
    localparam int DEG_W = 3;

    // Running product is multiplied 32 bits at a time
    localparam int CHUNK_BITS = 32;
    localparam int CHUNK_W    = 2;
    localparam int N_CHUNK    = 4;

    // Item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [15:0] var_0;
        logic signed [15:0] var_1;
        logic signed [15:0] var_2;
        logic signed [15:0] var_3;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] estimate;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic                  cap;        // latch variables, clear accumulator
        logic                  wr;         // write coefficient from input item
        logic                  ld_coef;    // running product <= coefficient
        logic [COEF_IDX_W-1:0] coef_idx;
        logic                  coef_zero;  // monomial position beyond the store
        logic                  mul;        // issue one chunk x variable product
        logic [VAR_IDX_W-1:0]  var_sel;
        logic [CHUNK_W-1:0]    chunk;
        logic                  chunk_top;  // top chunk is taken as signed
        logic                  commit;     // running product <= chunk sum
        logic                  acc;        // accumulate aligned term
        logic [DEG_W-1:0]      deg;        // total degree of current monomial
        logic                  rnd;        // add rounding half
        logic                  fin;        // saturate and load output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hdl/mpe_ctrl.sv
// ============================================================================
// mpe_ctrl - sequencing controller
// Walks the monomials in order, the factors of each and the 32-bit chunks of
// every partial product, and drives the datapath with one command per cycle.
// ============================================================================
module mpe_ctrl #(
    parameter int NUM_VARS   = 2,
    parameter int DEGREE     = 3,
    parameter int NUM_COEFFS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mpe_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    output mpe_pkg::t_dp_cmd  o_cmd,
    input  mpe_pkg::t_dp_sts  i_sts
);

    localparam int M_W = $clog2(NUM_COEFFS + 1);
    localparam int DW  = mpe_pkg::DEG_W;
    localparam int VW  = mpe_pkg::VAR_IDX_W;
    localparam int CW  = mpe_pkg::CHUNK_W;
    localparam int NV  = mpe_pkg::NUM_VAR_FIELDS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOAD   = 7'b0000010,
        S_FACT   = 7'b0000100,
        S_COMMIT = 7'b0001000,
        S_ACC    = 7'b0010000,
        S_RND    = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [DW-1:0]   r_e   [NV];
    logic [DW-1:0]   n_e   [NV];
    logic [DW-1:0]   r_rem [NV];
    logic [DW-1:0]   n_rem [NV];
    logic [DW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_chunk, n_chunk;
    logic [M_W-1:0]  r_m, n_m;

    logic            w_is_eval;
    logic [DW-1:0]   w_deg;
    logic [VW-1:0]   w_sel;
    logic            w_found;
    logic [VW-1:0]   w_pos;
    logic            w_more;
    logic            w_top;
    logic [DW-1:0]   w_k_inc;

    assign w_is_eval = (i_in_item.cmd == mpe_pkg::CMD_EVAL);

    // degree of the current monomial and first variable with factors left
    always_comb begin
        w_deg = '0;
        w_sel = '0;
        for (int i = 0; i < NV; i++) begin
            w_deg = w_deg + r_e[i];
        end
        for (int i = NV - 1; i >= 0; i--) begin
            if (r_rem[i] != '0) begin
                w_sel = VW'(i);
            end
        end
    end

    // next exponent tuple: bump the last position whose prefix still has room
    always_comb begin
        logic [DW:0] psum;
        psum    = '0;
        w_found = 1'b0;
        w_pos   = '0;
        for (int i = 0; i < NUM_VARS; i++) begin
            psum = psum + (DW+1)'(r_e[i]);
            if (psum < (DW+1)'(DEGREE)) begin
                w_found = 1'b1;
                w_pos   = VW'(i);
            end
        end
    end

    assign w_more  = w_found && ((32'(r_m) + 1) < NUM_COEFFS);
    assign w_k_inc = r_k + DW'(1);
    // product after k factors spans (k+3)/2 chunks; the last one is signed
    assign w_top   = (r_chunk == CW'(w_k_inc >> 1));

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_e     = r_e;
        n_rem   = r_rem;
        n_k     = r_k;
        n_chunk = r_chunk;
        n_m     = r_m;

        o_cmd           = '0;
        o_cmd.coef_idx  = mpe_pkg::COEF_IDX_W'(r_m);
        o_cmd.coef_zero = (32'(r_m) >= mpe_pkg::TAB_N);
        o_cmd.var_sel   = w_sel;
        o_cmd.chunk     = r_chunk;
        o_cmd.chunk_top = w_top;
        o_cmd.deg       = w_deg;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (w_is_eval) begin
                        o_cmd.cap = 1'b1;
                        for (int i = 0; i < NV; i++) begin
                            n_e[i] = '0;
                        end
                        n_m     = '0;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.wr = (32'(i_in_item.coef_index) < NUM_COEFFS);
                    end
                end
            end
            S_LOAD: begin
                o_cmd.ld_coef = 1'b1;
                n_rem   = r_e;
                n_k     = '0;
                n_chunk = '0;
                n_state = (w_deg != '0) ? S_FACT : S_ACC;
            end
            S_FACT: begin
                o_cmd.mul = 1'b1;
                if (w_top) begin
                    n_chunk = '0;
                    n_state = S_COMMIT;
                end else begin
                    n_chunk = r_chunk + CW'(1);
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_rem[w_sel] = r_rem[w_sel] - DW'(1);
                n_k          = w_k_inc;
                n_state      = (w_k_inc != w_deg) ? S_FACT : S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_m       = r_m + M_W'(1);
                if (w_more) begin
                    for (int i = 0; i < NV; i++) begin
                        if (VW'(i) == w_pos) begin
                            n_e[i] = r_e[i] + DW'(1);
                        end else if (VW'(i) > w_pos) begin
                            n_e[i] = '0;
                        end
                    end
                    n_state = S_LOAD;
                end else begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < NV; i++) begin
                r_e[i]   <= '0;
                r_rem[i] <= '0;
            end
            r_k     <= '0;
            r_chunk <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_e     <= n_e;
            r_rem   <= n_rem;
            r_k     <= n_k;
            r_chunk <= n_chunk;
            r_m     <= n_m;
        end
    end

endmodule

FILE: hdl/mpe_dp.sv
// ============================================================================
// mpe_dp - arithmetic datapath
// Coefficient store, shared 33x16 multiplier with chunk summing, wide
// accumulator, rounding, saturation and the output register.
// ============================================================================
module mpe_dp #(
    parameter int DEGREE = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpe_pkg::t_in_item  i_in_item,
    input  mpe_pkg::t_dp_cmd   i_cmd,
    output mpe_pkg::t_dp_sts   o_sts,
    output logic               o_out_valid,
    output mpe_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    // running product: coefficient times up to DEGREE variables
    localparam int PW    = 32 + 16 * DEGREE;
    // up to 70 terms of at most 31 + 15*DEGREE magnitude bits, plus sign
    localparam int ACC_W = 39 + 15 * DEGREE;
    localparam int RSH   = 8 + 8 * DEGREE;
    localparam int PAD_W = mpe_pkg::CHUNK_BITS * mpe_pkg::N_CHUNK;
    localparam int DW    = mpe_pkg::DEG_W;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (RSH - 1);

    logic signed [31:0]       r_tab     [mpe_pkg::TAB_N];
    logic                     r_tab_vld [mpe_pkg::TAB_N];
    logic signed [15:0]       r_vars    [mpe_pkg::NUM_VAR_FIELDS];
    logic signed [PW-1:0]     r_prod;
    logic [PW-1:0]            r_next;
    logic signed [48:0]       r_pp;
    logic                     r_pp_vld;
    logic [mpe_pkg::CHUNK_W-1:0] r_pp_sh;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_vld;
    mpe_pkg::t_out_item       r_out;

    logic signed [31:0]       w_coef;
    logic signed [PAD_W-1:0]  w_pad;
    logic [31:0]              w_chunk;
    logic signed [32:0]       w_mul_a;
    logic signed [15:0]       w_var;
    logic signed [48:0]       w_mul;
    logic signed [PW-1:0]     w_pp_ext;
    logic [PW-1:0]            w_pp_sh;
    logic [PW-1:0]            w_sum;
    logic [DW-1:0]            w_sh_deg;
    logic signed [ACC_W-1:0]  w_term_base;
    logic [ACC_W-1:0]         w_term;
    logic [ACC_W-1:0]         w_acc_add;
    logic signed [ACC_W-1:0]  w_shr;
    logic [ACC_W-32:0]        w_hi;
    logic                     w_sat;
    logic [31:0]              w_est;

    // unwritten entries read as the reset value, zero
    assign w_coef = (i_cmd.coef_zero || !r_tab_vld[i_cmd.coef_idx])
                    ? 32'sd0 : r_tab[i_cmd.coef_idx];

    // chunk multiply; lower chunks unsigned, top chunk signed
    assign w_pad    = PAD_W'(r_prod);
    assign w_chunk  = w_pad[{i_cmd.chunk, 5'b00000} +: 32];
    assign w_mul_a  = {i_cmd.chunk_top & w_chunk[31], w_chunk};
    assign w_var    = r_vars[i_cmd.var_sel];
    assign w_mul    = w_mul_a * w_var;

    // partial products land in the following cycle, aligned to their chunk
    assign w_pp_ext = PW'(r_pp);
    assign w_pp_sh  = w_pp_ext << {r_pp_sh, 5'b00000};
    assign w_sum    = r_next + w_pp_sh;

    // align term to a common fraction point: 8 bits per missing degree
    assign w_sh_deg    = DW'(DEGREE) - i_cmd.deg;
    assign w_term_base = ACC_W'(r_prod);
    assign w_term      = w_term_base << {w_sh_deg, 3'b000};
    assign w_acc_add   = r_acc + (i_cmd.rnd ? HALF : w_term);

    // saturate to Q16.16
    assign w_shr = r_acc >>> RSH;
    assign w_hi  = w_shr[ACC_W-1:31];
    assign w_sat = !((&w_hi) || !(|w_hi));
    assign w_est = !w_sat ? w_shr[31:0] :
                   (r_acc[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign o_sts.out_free = !r_out_vld || !i_out_stall;
    assign o_out_valid    = r_out_vld;
    assign o_out_item     = r_out;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mpe_pkg::TAB_N; i++) begin
                r_tab_vld[i] <= 1'b0;
            end
            r_pp_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_tab_vld[i_in_item.coef_index] <= 1'b1;
            end
            r_pp_vld <= i_cmd.mul;
            if (i_cmd.fin) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_tab[i_in_item.coef_index] <= i_in_item.coef_value;
        end
        if (i_cmd.cap) begin
            r_vars[0] <= i_in_item.var_0;
            r_vars[1] <= i_in_item.var_1;
            r_vars[2] <= i_in_item.var_2;
            r_vars[3] <= i_in_item.var_3;
        end
        if (i_cmd.mul) begin
            r_pp    <= w_mul;
            r_pp_sh <= i_cmd.chunk;
        end
        if (i_cmd.ld_coef) begin
            r_prod <= PW'(w_coef);
            r_next <= '0;
        end else if (i_cmd.commit) begin
            r_prod <= w_sum;
            r_next <= '0;
        end else if (r_pp_vld) begin
            r_next <= w_sum;
        end
        if (i_cmd.cap) begin
            r_acc <= '0;
        end else if (i_cmd.acc || i_cmd.rnd) begin
            r_acc <= w_acc_add;
        end
        if (i_cmd.fin) begin
            r_out.estimate  <= w_est;
            r_out.saturated <= w_sat;
        end
    end

endmodule

FILE: hdl/multivariate_polynomial_evaluator.sv
// ============================================================================
// multivariate_polynomial_evaluator - fixed-point polynomial evaluator
// Sums coefficient x monomial over all monomials of total degree <= DEGREE.
// ============================================================================
// A load item (cmd 0) writes one Q8.24 coefficient at its monomial position
// and gives no result; positions of NUM_COEFFS and above are
// dropped. An evaluate item (cmd 1) gives one Q16.16 result, rounded half up
// and saturated, with a flag set when clipped. Monomials run with the first
// variable's exponent slowest and the last fastest, e.g. for two variables
// of degree three: 1, y, y^2, y^3, x, xy, xy^2, x^2, x^2y, x^3. All sums are
// exact; the coefficient store reads zero after reset.
// Timing: the block takes no new item while evaluating. An evaluate item
// holds the input stalled until its result is loaded into the output
// register. The single 33x16 multiplier walks the growing product 32 bits
// per cycle, one variable factor at a time. A finished result waits in the
// output register while the next item is taken.
// ============================================================================
module multivariate_polynomial_evaluator #(
    parameter int NUM_VARS   = 2,
    parameter int DEGREE     = 3,
    parameter int NUM_COEFFS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input
    input  logic               i_in_valid,
    input  mpe_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    // result output
    output logic               o_out_valid,
    output mpe_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    mpe_pkg::t_dp_cmd w_cmd;
    mpe_pkg::t_dp_sts w_sts;

    // Controller: monomial / factor / chunk sequencing
    mpe_ctrl #(
        .NUM_VARS   (NUM_VARS),
        .DEGREE     (DEGREE),
        .NUM_COEFFS (NUM_COEFFS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // Datapath: store, multiplier, accumulator, output register
    mpe_dp #(
        .DEGREE (DEGREE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: hdl/mpe_checker.sv
// ============================================================================
// mpe_checker - port-level checks
// Watches the evaluator's ports; attached to the top level by bind.
// ============================================================================
module mpe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input mpe_pkg::t_in_item  i_in_item,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input mpe_pkg::t_out_item o_out_item,
    input logic               i_out_stall
);

    // an evaluate item occupies the block
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.cmd == mpe_pkg::CMD_EVAL)
        |=> o_in_stall)
        else $error("input not stalled after evaluate item");

    // a load item leaves the input unstalled
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.cmd == mpe_pkg::CMD_LOAD)
        |=> !o_in_stall)
        else $error("input stalled after load item");

    // clipped results sit at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.saturated
        |-> (o_out_item.estimate == 32'h7FFF_FFFF) ||
            (o_out_item.estimate == 32'h8000_0000))
        else $error("saturated flag without limit value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result dropped or changed");

endmodule

bind multivariate_polynomial_evaluator mpe_checker u_mpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

FILE: tb/tb_top.sv
// ============================================================================
// tb_top - self-checking bench for multivariate_polynomial_evaluator
// Feeds coefficient loads and evaluate items under random input gaps and
// output stalls. Each evaluate is predicted exactly at full width from the
// bench's own copy of the coefficient table, and results are checked in order.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Block configuration, kept in step with the instance below
    localparam int NUM_VARS    = 2;
    localparam int DEGREE      = 3;
    localparam int NUM_COEFFS  = 10;
    localparam int MONO_SPAN   = (DEGREE + 1) ** NUM_VARS;
    // Terms carry 24 + 8*DEGREE fraction bits; Q16.16 keeps 16 of them
    localparam int RND_SHIFT   = 8 + 8 * DEGREE;
    localparam int ITEM_TARGET = 1900;

    localparam logic signed [127:0] EST_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] EST_MIN = ~EST_MAX;

    // ------------------------------------------------------------------------
    // Coefficient table mirror, exact evaluator and in-order result checker
    // ------------------------------------------------------------------------
    class poly_checker;
        logic [31:0]         coef_store [NUM_COEFFS];
        mpe_pkg::t_out_item  pending_estimates [$];
        int                  errors;

        function new();
            errors = 0;
            foreach (coef_store[i]) coef_store[i] = '0;
        endfunction

        // Sum of coefficient x monomial, all at full precision, then rounded
        // half up to Q16.16 and clipped.
        function mpe_pkg::t_out_item evaluate(mpe_pkg::t_in_item it);
            logic signed [127:0] acc;
            logic signed [127:0] term;
            logic signed [127:0] scaled;
            logic signed [127:0] vars [4];
            int                  exps [4];
            int                  rest;
            int                  deg;
            int                  m;
            mpe_pkg::t_out_item  res;
            vars[0] = {{112{it.var_0[15]}}, it.var_0};
            vars[1] = {{112{it.var_1[15]}}, it.var_1};
            vars[2] = {{112{it.var_2[15]}}, it.var_2};
            vars[3] = {{112{it.var_3[15]}}, it.var_3};
            acc = '0;
            m   = 0;
            // last variable's exponent runs fastest; skip over-degree tuples
            for (int k = 0; k < MONO_SPAN && m < NUM_COEFFS; k++) begin
                rest = k;
                deg  = 0;
                for (int i = NUM_VARS - 1; i >= 0; i--) begin
                    exps[i] = rest % (DEGREE + 1);
                    rest    = rest / (DEGREE + 1);
                    deg     = deg + exps[i];
                end
                if (deg > DEGREE) continue;
                term = {{96{coef_store[m][31]}}, coef_store[m]};
                m++;
                for (int i = 0; i < NUM_VARS; i++)
                    for (int j = 0; j < exps[i]; j++)
                        term = term * vars[i];
                acc = acc + (term <<< (8 * (DEGREE - deg)));
            end
            acc    = acc + (128'sd1 <<< (RND_SHIFT - 1));
            scaled = acc >>> RND_SHIFT;
            if (scaled > EST_MAX) begin
                res.estimate  = 32'h7FFF_FFFF;
                res.saturated = 1'b1;
            end else if (scaled < EST_MIN) begin
                res.estimate  = 32'h8000_0000;
                res.saturated = 1'b1;
            end else begin
                res.estimate  = scaled[31:0];
                res.saturated = 1'b0;
            end
            return res;
        endfunction

        function void note_item(mpe_pkg::t_in_item it);
            if (it.cmd == mpe_pkg::CMD_LOAD) begin
                if (it.coef_index < NUM_COEFFS) coef_store[it.coef_index] = it.coef_value;
            end else begin
                pending_estimates.insert(pending_estimates.size(), evaluate(it));
            end
        endfunction

        function void check_result(mpe_pkg::t_out_item got);
            mpe_pkg::t_out_item want;
            if (pending_estimates.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result estimate %h saturated %b",
                             $realtime, got.estimate, got.saturated);
                return;
            end
            want = pending_estimates.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: expected estimate %h saturated %b, got %h %b",
                             $realtime, want.estimate, want.saturated,
                             got.estimate, got.saturated);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    mpe_pkg::t_in_item  in_item   = '0;
    logic               in_stall;
    logic               out_valid;
    mpe_pkg::t_out_item out_item;
    logic               out_stall = 1'b0;

    poly_checker sb;
    int          sent  = 0;
    // when set, both sides run flat out with no gaps or stalls
    bit          calm  = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    multivariate_polynomial_evaluator #(
        .NUM_VARS   (NUM_VARS),
        .DEGREE     (DEGREE),
        .NUM_COEFFS (NUM_COEFFS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    // ------------------------------------------------------------------------
    // Random shaping helpers
    // ------------------------------------------------------------------------
    // Idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)   return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_coef();
        logic [31:0] r;
        case ($urandom_range(0, 5))
            0:       r = $urandom;
            1, 2:    r = $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000; // within +-2.0
            3:       r = '0;
            4: begin
                case ($urandom_range(0, 3))
                    0:       r = 32'h7FFF_FFFF;
                    1:       r = 32'h8000_0000;
                    2:       r = 32'hFFFF_FFFF;
                    default: r = 32'h0000_0001;
                endcase
            end
            default: r = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] rand_var();
        logic [31:0] r;
        case ($urandom_range(0, 5))
            0:       r = $urandom;
            1, 2, 3: r = $urandom_range(0, 1023) - 512;     // within +-2.0
            4:       r = $urandom_range(0, 8191) - 4096;    // within +-16.0
            default: begin
                case ($urandom_range(0, 4))
                    0:       r = 32'h7FFF;
                    1:       r = 32'h8000;
                    2:       r = 32'hFFFF;
                    3:       r = 32'h0000;
                    default: r = 32'h0001;
                endcase
            end
        endcase
        return r[15:0];
    endfunction

    // Mostly valid table positions; some beyond the table, which are dropped
    function automatic logic [3:0] rand_index();
        if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, NUM_COEFFS - 1));
    endfunction

    function automatic mpe_pkg::t_in_item load_item(logic [3:0] idx, logic [31:0] value);
        mpe_pkg::t_in_item it;
        it            = '0;
        it.cmd        = mpe_pkg::CMD_LOAD;
        it.coef_index = idx;
        it.coef_value = value;
        // unused fields carry noise
        it.var_0      = 16'($urandom);
        it.var_1      = 16'($urandom);
        it.var_2      = 16'($urandom);
        it.var_3      = 16'($urandom);
        return it;
    endfunction

    function automatic mpe_pkg::t_in_item eval_item(logic [15:0] v0, logic [15:0] v1,
                                                    logic [15:0] v2, logic [15:0] v3);
        mpe_pkg::t_in_item it;
        it.cmd        = mpe_pkg::CMD_EVAL;
        it.coef_index = 4'($urandom);
        it.coef_value = $urandom;
        it.var_0      = v0;
        it.var_1      = v1;
        it.var_2      = v2;
        it.var_3      = v3;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: present one item, hold it until taken, then maybe idle.
    // Valid stays high when no gap follows, so back-to-back items need only
    // one assignment per edge.
    // ------------------------------------------------------------------------
    task automatic send_item(mpe_pkg::t_in_item it);
        int gap;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Table extremes, dropped loads, saturation both ways and rounding of halves
    task automatic run_directed();
        send_item(eval_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));   // empty table
        send_item(load_item(4'd0, 32'h0100_0000));                      // constant 1.0
        send_item(eval_item(16'h0000, 16'h0000, 16'h8000, 16'h7FFF));
        send_item(load_item(4'd10, 32'h7FFF_FFFF));                     // beyond the table
        send_item(load_item(4'd15, 32'h8000_0000));
        send_item(eval_item(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
        send_item(load_item(4'(NUM_COEFFS - 1), 32'h7FFF_FFFF));        // x^3 term
        send_item(eval_item(16'h7FFF, 16'h0000, 16'h0000, 16'h0000));   // clips high
        send_item(eval_item(16'h8000, 16'h0000, 16'h0000, 16'h0000));   // clips low
        send_item(load_item(4'(NUM_COEFFS - 1), 32'h0000_0000));
        send_item(load_item(4'd0, 32'h8000_0000));                      // -128.0
        send_item(eval_item(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(load_item(4'd0, 32'h0000_0080));                      // +half LSB
        send_item(eval_item(16'h1234, 16'h4321, 16'h0000, 16'h0000));
        send_item(load_item(4'd0, 32'hFFFF_FF80));                      // -half LSB
        send_item(eval_item(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        for (int i = 1; i < NUM_COEFFS - 1; i++)
            send_item(load_item(4'(i), i[0] ? 32'h7FFF_FFFF : 32'h8000_0000));
        send_item(eval_item(16'h8000, 16'h8000, 16'h0000, 16'h0000));
        send_item(eval_item(16'hFFFF, 16'h0001, 16'h0000, 16'h0000));
    endtask

    // Bursts of loads followed by evaluates; sometimes a whole new table
    task automatic run_random();
        int n_load;
        int n_eval;
        while (sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0) begin
                for (int i = 0; i < NUM_COEFFS; i++)
                    send_item(load_item(4'(i), rand_coef()));
            end else begin
                n_load = $urandom_range(0, 3);
                repeat (n_load) send_item(load_item(rand_index(), rand_coef()));
            end
            n_eval = $urandom_range(1, 3);
            repeat (n_eval)
                send_item(eval_item(rand_var(), rand_var(), rand_var(), rand_var()));
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: check each taken result, then choose the next stall.
    // Values are read straight after the edge, before any update lands.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
            if (stall_left != 0) stall_left--;
            if (stall_left == 0) begin
                if (out_stall) begin
                    out_stall <= 1'b0;
                end else begin
                    stall_left = pick_gap();
                    out_stall <= (stall_left != 0);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        // drain, then keep the clock running to catch strays
        while (sb.pending_estimates.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_estimates.size() == 0) begin
            $display("multivariate_polynomial_evaluator: match");
        end else begin
            $display("multivariate_polynomial_evaluator: mismatch");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #4_000_000;
        $display("multivariate_polynomial_evaluator: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
hdl/mpe_pkg.sv
hdl/mpe_ctrl.sv
hdl/mpe_dp.sv
hdl/multivariate_polynomial_evaluator.sv
hdl/mpe_checker.sv
tb/tb_top.sv
